[rtl/mexp_pkg.sv]
package mexp_pkg;

    localparam int BASE_WIDTH = 32;
    localparam int EXP_WIDTH = 32;
    localparam int MOD_WIDTH = 31;

    // multiplier operand b carries either the raw base or a reduced residue
    localparam int OPB_WIDTH = (BASE_WIDTH > MOD_WIDTH) ? BASE_WIDTH : MOD_WIDTH;
    localparam int MUL_CNT_WIDTH = $clog2(OPB_WIDTH + 1);
    localparam int EXP_CNT_WIDTH = $clog2(EXP_WIDTH);

    localparam int IN_TDATA_WIDTH = ((BASE_WIDTH + EXP_WIDTH + 7) / 8) * 8;
    localparam int OUT_TDATA_WIDTH = ((MOD_WIDTH + 7) / 8) * 8;

    typedef logic [MOD_WIDTH-1:0] residue_t;

    typedef struct packed {
        logic                 start;
        residue_t             a;
        logic [OPB_WIDTH-1:0] b;
    } mul_req_t;

    typedef struct packed {
        logic     done;
        residue_t result;
    } mul_rsp_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_REDUCE,
        ST_SQUARE,
        ST_MULT,
        ST_DONE
    } state_t;

endpackage

[rtl/modular_exponentiation.sv]
// Computes base_value ** exponent mod modulus by left-to-right square and
// multiply. All arithmetic runs through one shift-add modular multiplier that
// retires one operand bit per cycle. An item takes one reduction of the base,
// then 32 squarings plus one multiply per set exponent bit, then an output
// load. A modulus of 0 or 1 gives 0 with no multiplication. s_tready is high
// only between items; the result sits in an output register, so the next beat
// can be taken while it waits on m_tready. Write the modulus only while the
// block is idle.
module modular_exponentiation (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   cfg_we,
    input  logic [mexp_pkg::MOD_WIDTH-1:0]         cfg_wdata,
    input  logic                                   s_tvalid,
    output logic                                   s_tready,
    // [31:0] base_value, [63:32] exponent
    input  logic [mexp_pkg::IN_TDATA_WIDTH-1:0]    s_tdata,
    output logic                                   m_tvalid,
    input  logic                                   m_tready,
    // [30:0] power_mod, [31] zero
    output logic [mexp_pkg::OUT_TDATA_WIDTH-1:0]   m_tdata
);
    import mexp_pkg::*;

    state_t                   state_reg;
    state_t                   state_next;
    residue_t                 modulus_reg;
    residue_t                 acc_reg;
    residue_t                 base_reg;
    logic [BASE_WIDTH-1:0]    raw_base_reg;
    logic [EXP_WIDTH-1:0]     exp_reg;
    logic [EXP_CNT_WIDTH-1:0] bit_cnt_reg;
    logic                     issued_reg;
    residue_t                 out_reg;
    logic                     out_valid_reg;

    mul_req_t mul_req;
    mul_rsp_t mul_rsp;

    logic in_beat;
    logic out_load;
    logic mod_trivial;
    logic last_bit;

    mexp_mulmod u_mulmod (
        .clk     (clk),
        .rst_n   (rst_n),
        .modulus (modulus_reg),
        .req     (mul_req),
        .rsp     (mul_rsp)
    );

    assign mod_trivial = (modulus_reg <= MOD_WIDTH'(1));
    assign last_bit = (bit_cnt_reg == EXP_CNT_WIDTH'(EXP_WIDTH - 1));
    assign in_beat = s_tvalid && s_tready;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_beat)
                begin
                    state_next = mod_trivial ? ST_DONE : ST_REDUCE;
                end
            end
            ST_REDUCE:
            begin
                if (mul_rsp.done)
                begin
                    state_next = ST_SQUARE;
                end
            end
            ST_SQUARE:
            begin
                if (mul_rsp.done)
                begin
                    if (exp_reg[EXP_WIDTH-1])
                        state_next = ST_MULT;
                    else if (last_bit)
                        state_next = ST_DONE;
                    else
                        state_next = ST_SQUARE;
                end
            end
            ST_MULT:
            begin
                if (mul_rsp.done)
                begin
                    state_next = last_bit ? ST_DONE : ST_SQUARE;
                end
            end
            ST_DONE:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        s_tready = 1'b0;
        out_load = 1'b0;
        mul_req.start = 1'b0;
        mul_req.a = acc_reg;
        mul_req.b = OPB_WIDTH'(acc_reg);
        case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
            end
            ST_REDUCE:
            begin
                mul_req.start = !issued_reg;
                mul_req.a = MOD_WIDTH'(1);
                mul_req.b = OPB_WIDTH'(raw_base_reg);
            end
            ST_SQUARE:
            begin
                mul_req.start = !issued_reg;
            end
            ST_MULT:
            begin
                mul_req.start = !issued_reg;
                mul_req.b = OPB_WIDTH'(base_reg);
            end
            ST_DONE:
            begin
                out_load = !out_valid_reg || m_tready;
            end
            default:
            begin
                s_tready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            modulus_reg <= MOD_WIDTH'(1);
            issued_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            bit_cnt_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
                modulus_reg <= cfg_wdata;

            if (mul_rsp.done)
                issued_reg <= 1'b0;
            else if (mul_req.start)
                issued_reg <= 1'b1;

            if (out_load)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;

            if (in_beat)
                bit_cnt_reg <= '0;
            else if (mul_rsp.done && (state_reg == ST_MULT ||
                     (state_reg == ST_SQUARE && !exp_reg[EXP_WIDTH-1])))
                bit_cnt_reg <= bit_cnt_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_beat)
        begin
            raw_base_reg <= s_tdata[BASE_WIDTH-1:0];
            exp_reg <= s_tdata[BASE_WIDTH +: EXP_WIDTH];
            acc_reg <= mod_trivial ? '0 : MOD_WIDTH'(1);
        end
        else if (mul_rsp.done)
        begin
            case (state_reg)
                ST_REDUCE:
                begin
                    base_reg <= mul_rsp.result;
                end
                ST_SQUARE:
                begin
                    acc_reg <= mul_rsp.result;
                    if (!exp_reg[EXP_WIDTH-1])
                        exp_reg <= {exp_reg[EXP_WIDTH-2:0], 1'b0};
                end
                ST_MULT:
                begin
                    acc_reg <= mul_rsp.result;
                    exp_reg <= {exp_reg[EXP_WIDTH-2:0], 1'b0};
                end
                default:
                begin
                    acc_reg <= acc_reg;
                end
            endcase
        end
        if (out_load)
            out_reg <= acc_reg;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata = OUT_TDATA_WIDTH'(out_reg);

    a_done_in_compute: assert property (@(posedge clk) disable iff (!rst_n)
        mul_rsp.done |-> (state_reg == ST_REDUCE || state_reg == ST_SQUARE ||
                          state_reg == ST_MULT))
        else $error("multiplier finished outside a compute state");

    a_acc_reduced: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SQUARE || state_reg == ST_MULT) |-> acc_reg < modulus_reg)
        else $error("accumulator not reduced");

    a_out_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (out_reg < modulus_reg || out_reg == '0))
        else $error("result not below modulus");

    a_one_op: assert property (@(posedge clk) disable iff (!rst_n)
        mul_req.start |-> !issued_reg)
        else $error("multiplier started twice");

endmodule

[rtl/mexp_mulmod.sv]
module mexp_mulmod (
    input  logic                clk,
    input  logic                rst_n,
    input  mexp_pkg::residue_t  modulus,
    input  mexp_pkg::mul_req_t  req,
    output mexp_pkg::mul_rsp_t  rsp
);
    import mexp_pkg::*;

    logic                     busy_reg;
    logic                     done_reg;
    logic [MUL_CNT_WIDTH-1:0] cnt_reg;
    residue_t                 acc_reg;
    residue_t                 a_reg;
    logic [OPB_WIDTH-1:0]     b_reg;

    logic [MOD_WIDTH:0] m_ext;
    logic [MOD_WIDTH:0] dbl;
    logic [MOD_WIDTH:0] red1;
    logic [MOD_WIDTH:0] sum;
    residue_t           acc_next;

    // one bit of b per cycle, msb first: acc = 2*acc + bit*a, reduced twice
    always_comb
    begin
        m_ext = {1'b0, modulus};
        dbl = {acc_reg, 1'b0};
        red1 = (dbl >= m_ext) ? (dbl - m_ext) : dbl;
        sum = red1 + (b_reg[OPB_WIDTH-1] ? {1'b0, a_reg} : '0);
        acc_next = (sum >= m_ext) ? MOD_WIDTH'(sum - m_ext) : sum[MOD_WIDTH-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == MUL_CNT_WIDTH'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
            else if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg <= MUL_CNT_WIDTH'(OPB_WIDTH);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (busy_reg)
        begin
            acc_reg <= acc_next;
            b_reg <= {b_reg[OPB_WIDTH-2:0], 1'b0};
        end
        else if (req.start)
        begin
            acc_reg <= '0;
            a_reg <= req.a;
            b_reg <= req.b;
        end
    end

    assign rsp.done = done_reg;
    assign rsp.result = acc_reg;

endmodule

[dv/tb_top.sv]
module tb_top;

    import mexp_pkg::*;

    localparam int RESET_CYCLES = 8;
    localparam int DRAIN_CYCLES = 60;
    localparam int HOLD_CYCLES = 6000;
    localparam int WATCHDOG_LIMIT = 25000;
    localparam int ITEMS_PER_PHASE = 37;
    localparam int NUM_PHASES = 7;
    localparam int NUM_VECS = 24;

    logic                       clk;
    logic                       rst_n;
    logic                       cfg_we;
    logic [MOD_WIDTH-1:0]       cfg_wdata;
    logic                       s_tvalid;
    logic                       s_tready;
    logic [IN_TDATA_WIDTH-1:0]  s_tdata;
    logic                       m_tvalid;
    logic                       m_tready;
    logic [OUT_TDATA_WIDTH-1:0] m_tdata;

    typedef struct packed {
        logic [MOD_WIDTH-1:0]  modulus;
        logic [BASE_WIDTH-1:0] base;
        logic [EXP_WIDTH-1:0]  expo;
        logic                  typed;
        logic [MOD_WIDTH-1:0]  power;
    } vec_t;

    // modulus, base, exponent, typed, power (power used only when typed)
    vec_t dir_vecs [NUM_VECS] = '{
        '{31'd1,          32'd5,          32'd0,          1'b1, 31'd0},
        '{31'd1,          32'hffffffff,   32'hffffffff,   1'b1, 31'd0},
        '{31'd1,          32'd0,          32'd0,          1'b1, 31'd0},
        '{31'h7fffffff,   32'd0,          32'd0,          1'b1, 31'd1},
        '{31'h7fffffff,   32'd0,          32'd5,          1'b1, 31'd0},
        '{31'h7fffffff,   32'd1,          32'hffffffff,   1'b1, 31'd1},
        '{31'h7fffffff,   32'hffffffff,   32'd0,          1'b1, 31'd1},
        '{31'h7fffffff,   32'hffffffff,   32'd1,          1'b1, 31'd1},
        '{31'h7fffffff,   32'd2,          32'd31,         1'b1, 31'd1},
        '{31'h7fffffff,   32'd2,          32'd30,         1'b1, 31'h40000000},
        '{31'h7fffffff,   32'h7fffffff,   32'd3,          1'b1, 31'd0},
        '{31'h7fffffff,   32'h80000000,   32'd2,          1'b1, 31'd1},
        '{31'h7fffffff,   32'd3,          32'd5,          1'b1, 31'd243},
        '{31'h7fffffff,   32'hffffffff,   32'hffffffff,   1'b0, 31'd0},
        '{31'h7fffffff,   32'haaaaaaaa,   32'h55555555,   1'b0, 31'd0},
        '{31'h7fffffff,   32'h55555555,   32'haaaaaaaa,   1'b0, 31'd0},
        '{31'h7fffffff,   32'h12345678,   32'h9abcdef0,   1'b0, 31'd0},
        '{31'd0,          32'd12345,      32'd678,        1'b1, 31'd0},
        '{31'd0,          32'd0,          32'd0,          1'b1, 31'd0},
        '{31'd2,          32'd3,          32'hffffffff,   1'b1, 31'd1},
        '{31'd2,          32'd4,          32'd7,          1'b1, 31'd0},
        '{31'd2,          32'hffffffff,   32'd0,          1'b1, 31'd1},
        '{31'd3,          32'd2,          32'h80000000,   1'b1, 31'd1},
        '{31'd3,          32'hfffffffe,   32'h0000ffff,   1'b0, 31'd0}
    };

    logic [MOD_WIDTH-1:0] mod_reg;
    logic [MOD_WIDTH-1:0] power_q [$];
    int                   err_cnt;
    int                   results_seen;
    bit                   idle_on;

    modular_exponentiation u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic logic [MOD_WIDTH-1:0] expmod_predict(logic [BASE_WIDTH-1:0] b,
                                                          logic [EXP_WIDTH-1:0] e,
                                                          logic [MOD_WIDTH-1:0] m);
        logic [63:0] acc;
        logic [63:0] rb;
        logic [63:0] mm;
        int          i;
        if (m <= 1)
            return '0;
        mm = 64'(m);
        rb = 64'(b) % mm;
        acc = 64'd1;
        for (i = EXP_WIDTH - 1; i >= 0; i--)
        begin
            acc = (acc * acc) % mm;
            if (e[i])
                acc = (acc * rb) % mm;
        end
        return acc[MOD_WIDTH-1:0];
    endfunction

    function automatic int pick_gap();
        int r;
        if (!idle_on)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        else if (r < 92)
            return $urandom_range(1, 4);
        else
            return $urandom_range(20, 60);
    endfunction

    task automatic wait_idle();
        while (power_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic set_modulus(logic [MOD_WIDTH-1:0] m);
        wait_idle();
        cfg_we <= 1'b1;
        cfg_wdata <= m;
        @(posedge clk);
        cfg_we <= 1'b0;
        mod_reg = m;
    endtask

    // typed: use the given power instead of the predictor
    task automatic send_item(logic [BASE_WIDTH-1:0] b, logic [EXP_WIDTH-1:0] e,
                             bit typed, logic [MOD_WIDTH-1:0] power);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {e, b};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        power_q.push_back(typed ? power : expmod_predict(b, e, mod_reg));
    endtask

    task automatic send_random();
        logic [BASE_WIDTH-1:0] b;
        logic [EXP_WIDTH-1:0]  e;
        int                    r;
        r = $urandom_range(0, 9);
        case (r)
            0: b = '0;
            1: b = '1;
            2: b = 32'(mod_reg) * $urandom_range(0, 2);
            3: b = 32'(mod_reg) - 1;
            default: b = $urandom();
        endcase
        r = $urandom_range(0, 9);
        case (r)
            0: e = '0;
            1: e = '1;
            2: e = $urandom_range(0, 16);
            default: e = $urandom();
        endcase
        send_item(b, e, 1'b0, '0);
    endtask

    // result side: random stalls plus one long hold-off once the run is underway
    initial
    begin
        int  stall_left;
        int  r;
        bit  held;
        logic [MOD_WIDTH-1:0] exp_power;
        stall_left = 0;
        held = 1'b0;
        m_tready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && m_tvalid && m_tready)
            begin
                results_seen++;
                if (power_q.size() == 0)
                begin
                    $display("%0t: unexpected result beat, actual %0d", $time,
                             m_tdata[MOD_WIDTH-1:0]);
                    err_cnt++;
                end
                else
                begin
                    exp_power = power_q.pop_front();
                    if (m_tdata[MOD_WIDTH-1:0] !== exp_power)
                    begin
                        $display("%0t: power_mod mismatch, expected %0d actual %0d",
                                 $time, exp_power, m_tdata[MOD_WIDTH-1:0]);
                        err_cnt++;
                    end
                    if (m_tdata[OUT_TDATA_WIDTH-1:MOD_WIDTH] !== '0)
                    begin
                        $display("%0t: tdata pad mismatch, expected 0 actual %0h", $time,
                                 m_tdata[OUT_TDATA_WIDTH-1:MOD_WIDTH]);
                        err_cnt++;
                    end
                end
            end
            if (!held && results_seen == 30)
            begin
                held = 1'b1;
                stall_left = HOLD_CYCLES;
            end
            if (stall_left > 0)
            begin
                stall_left--;
                m_tready <= 1'b0;
            end
            else if (!idle_on)
                m_tready <= 1'b1;
            else
            begin
                r = $urandom_range(0, 99);
                if (r < 70)
                    m_tready <= 1'b1;
                else
                begin
                    m_tready <= 1'b0;
                    stall_left = (r < 95) ? $urandom_range(0, 3) : $urandom_range(20, 60);
                end
            end
        end
    end

    initial
    begin
        int idle_cnt;
        idle_cnt = 0;
        forever
        begin
            @(posedge clk);
            if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
                idle_cnt = 0;
            else
                idle_cnt++;
            if (idle_cnt >= WATCHDOG_LIMIT)
            begin
                $display("%0t: watchdog expired, %0d results outstanding", $time,
                         power_q.size());
                $display("FAILURE");
                $finish;
            end
        end
    end

    initial
    begin
        logic [31:0] r;
        logic [MOD_WIDTH-1:0] phase_mod [NUM_PHASES];
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_wdata = '0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        err_cnt = 0;
        results_seen = 0;
        idle_on = 1'b1;
        mod_reg = 31'd1;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_vecs[i])
        begin
            if (dir_vecs[i].modulus != mod_reg)
            begin
                s_tvalid <= 1'b0;
                set_modulus(dir_vecs[i].modulus);
            end
            send_item(dir_vecs[i].base, dir_vecs[i].expo, dir_vecs[i].typed,
                      dir_vecs[i].power);
        end

        phase_mod[0] = 31'h7fffffff;
        r = $urandom();
        phase_mod[1] = r[MOD_WIDTH-1:0] | 31'h40000000;
        phase_mod[2] = MOD_WIDTH'($urandom_range(2, 1000));
        phase_mod[3] = 31'd1;
        phase_mod[4] = 31'd0;
        phase_mod[5] = 31'h40000001;
        r = $urandom();
        phase_mod[6] = r[MOD_WIDTH-1:0];

        for (int ph = 0; ph < NUM_PHASES; ph++)
        begin
            s_tvalid <= 1'b0;
            set_modulus(phase_mod[ph]);
            idle_on = (ph != 2);
            for (int n = 0; n < ITEMS_PER_PHASE; n++)
                send_random();
        end
        s_tvalid <= 1'b0;
        idle_on = 1'b1;

        while (power_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (err_cnt == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
